/* rtl/float32_multiplier_assert.svh */
// Assertion macros for the float32 multiplier checker.
`ifndef FLOAT32_MULTIPLIER_ASSERT_SVH
`define FLOAT32_MULTIPLIER_ASSERT_SVH

// Property that holds after the given cycle relation, disabled during reset.
`define FM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define FM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/fmul_pkg.sv */
`default_nettype none
package fmul_pkg;

  localparam int unsigned ExpW  = 8;
  localparam int unsigned FracW = 23;
  localparam int unsigned SigW  = FracW + 1;
  localparam int unsigned ProdW = 2 * SigW;
  localparam int unsigned LzcW  = 5;

  localparam logic [31:0] SignBit    = 32'h8000_0000;
  localparam logic [31:0] ExpMask    = 32'h7F80_0000;
  localparam logic [31:0] QuietBit   = 32'h0040_0000;
  localparam logic [31:0] DefaultNan = 32'h7FC0_0000;

  // Special-case class of an operand pair.
  typedef enum logic [2:0] {
    CLS_NAN_A,
    CLS_NAN_B,
    CLS_INVALID,
    CLS_INF,
    CLS_ZERO,
    CLS_FINITE
  } cls_t;

  // Count leading zeros of a 24-bit significand.
  function automatic logic [LzcW-1:0] lzc24(input logic [SigW-1:0] m);
    logic [LzcW-1:0] n;
    logic            found;
    n = LzcW'(SigW);
    found = 1'b0;
    for (int i = SigW - 1; i >= 0; i--) begin
      if (!found && m[i]) begin
        n = LzcW'(SigW - 1 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

/* rtl/float32_multiplier.sv */
// IEEE-754 single-precision multiplier, round to nearest even, full subnormal,
// infinity and NaN handling. A pair of operands is taken whenever start is high
// (busy is always low); its product appears with done high after classification,
// subnormal normalization and the 24x24 significand multiply into the product
// register, then normalization and rounding into the result register.
// One product per cycle is sustained. The receiver cannot stall: done is a
// one-cycle strobe and the result is lost if not sampled then.
`default_nettype none
module float32_multiplier (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output      logic        busy,
  input  wire logic [31:0] operand_a,
  input  wire logic [31:0] operand_b,
  output      logic        done,
  output      logic [31:0] product,
  output      logic        underflow_flag,
  output      logic        overflow_flag
);

  localparam int unsigned SigW  = fmul_pkg::SigW;
  localparam int unsigned ProdW = fmul_pkg::ProdW;
  localparam int unsigned LzcW  = fmul_pkg::LzcW;

  // Stage 1: classify, unpack, normalize subnormals, multiply.
  logic [30:0]       ma, mb;
  logic              nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  fmul_pkg::cls_t    cls;
  logic [SigW-1:0]   sa, sb;
  logic [LzcW-1:0]   la, lb;
  logic signed [9:0] ea, eb;

  assign busy = 1'b0;

  always_comb begin
    ma = operand_a[30:0];
    mb = operand_b[30:0];
    inf_a  = ma == fmul_pkg::ExpMask[30:0];
    inf_b  = mb == fmul_pkg::ExpMask[30:0];
    nan_a  = ma[30:23] == 8'hFF && ma[22:0] != '0;
    nan_b  = mb[30:23] == 8'hFF && mb[22:0] != '0;
    zero_a = ma == '0;
    zero_b = mb == '0;
    if (nan_a) cls = fmul_pkg::CLS_NAN_A;
    else if (nan_b) cls = fmul_pkg::CLS_NAN_B;
    else if ((inf_a || inf_b) && (zero_a || zero_b)) cls = fmul_pkg::CLS_INVALID;
    else if (inf_a || inf_b) cls = fmul_pkg::CLS_INF;
    else if (zero_a || zero_b) cls = fmul_pkg::CLS_ZERO;
    else cls = fmul_pkg::CLS_FINITE;
    la = fmul_pkg::lzc24({1'b0, ma[22:0]});
    lb = fmul_pkg::lzc24({1'b0, mb[22:0]});
    if (ma[30:23] == '0) begin
      sa = SigW'({1'b0, ma[22:0]} << la);
      ea = 10'(-126) - 10'(la);
    end else begin
      sa = {1'b1, ma[22:0]};
      ea = 10'({2'b00, ma[30:23]}) - 10'(127);
    end
    if (mb[30:23] == '0) begin
      sb = SigW'({1'b0, mb[22:0]} << lb);
      eb = 10'(-126) - 10'(lb);
    end else begin
      sb = {1'b1, mb[22:0]};
      eb = 10'({2'b00, mb[30:23]}) - 10'(127);
    end
  end

  logic                v1;
  fmul_pkg::cls_t      cls1;
  logic                sign1;
  logic [31:0]         a1, b1;
  logic [ProdW-1:0]    p1;
  logic signed [10:0]  e1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    cls1  <= cls;
    sign1 <= operand_a[31] ^ operand_b[31];
    a1    <= operand_a;
    b1    <= operand_b;
    p1    <= sa * sb;
    e1    <= 11'(ea) + 11'(eb);
  end

  // Stage 2: normalize, round, pack.
  logic [ProdW-1:0]   pn;
  logic signed [10:0] be;
  logic [6:0]         sh;
  logic [ProdW-1:0]   q, rem;
  logic [ProdW:0]     half;
  logic [ProdW:0]     qr;
  logic [31:0]        res;
  logic [32:0]        rn;

  always_comb begin
    if (p1[ProdW-1]) begin
      pn = p1;
      be = e1 + 11'(128);
    end else begin
      pn = p1 << 1;
      be = e1 + 11'(127);
    end
    // Everything rounds to zero once the shift passes the product width.
    if (be >= 11'sd1) sh = 7'd24;
    else if (be < -11'sd23) sh = 7'd49;
    else sh = 7'(11'sd25 - be);
    q    = pn >> sh;
    rem  = pn & ((ProdW'(1) << sh) - ProdW'(1));
    half = (ProdW+1)'(1) << (sh - 7'd1);
    qr   = {1'b0, q} + (ProdW+1)'({1'b0, rem} > half || ({1'b0, rem} == half && q[0]));
    rn   = 33'({be[7:0] - 8'd1, 23'd0}) + 33'(qr);
    res  = '0;
    case (cls1)
      fmul_pkg::CLS_NAN_A:   res = a1 | fmul_pkg::QuietBit;
      fmul_pkg::CLS_NAN_B:   res = b1 | fmul_pkg::QuietBit;
      fmul_pkg::CLS_INVALID: res = fmul_pkg::DefaultNan;
      fmul_pkg::CLS_INF:     res = {sign1, fmul_pkg::ExpMask[30:0]};
      fmul_pkg::CLS_ZERO:    res = {sign1, 31'd0};
      fmul_pkg::CLS_FINITE: begin
        if (be >= 11'sd255) res = {sign1, fmul_pkg::ExpMask[30:0]};
        else if (be >= 11'sd1) begin
          if (rn >= 33'(fmul_pkg::ExpMask)) res = {sign1, fmul_pkg::ExpMask[30:0]};
          else res = {sign1, rn[30:0]};
        end else res = {sign1, qr[30:0]};
      end
      default: res = fmul_pkg::DefaultNan;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v1;
    product        <= res;
    underflow_flag <= res[30:23] == '0;
    overflow_flag  <= res[30:0] == fmul_pkg::ExpMask[30:0];
  end

endmodule
`default_nettype wire

/* rtl/fmul_checker.sv */
`default_nettype none
`include "float32_multiplier_assert.svh"
module fmul_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [31:0] product,
  input wire logic        underflow_flag,
  input wire logic        overflow_flag
);

  `FM_ASSERT(a_done_lat, clk, rst, start && !busy |=> ##1 done, "product not delivered")
  `FM_ASSERT(a_no_spur, clk, rst, !$past(start, 2) && !$past(rst, 1) |-> !done, "spurious done")
  `FM_ASSERT(a_flags_excl, clk, rst, done |-> !(underflow_flag && overflow_flag), "both flags set")
  `FM_ASSERT(a_ovf_inf, clk, rst, done && overflow_flag |-> product[30:23] == 8'hFF && product[22:0] == 23'd0, "overflow without infinity")
  `FM_ASSERT_ALWAYS(a_never_busy, clk, !busy, "busy raised")

endmodule

bind float32_multiplier fmul_checker u_fmul_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .product(product), .underflow_flag(underflow_flag), .overflow_flag(overflow_flag)
);
`default_nettype wire

/* tb/float32_multiplier_tb.sv */
`timescale 1ns / 100ps
`default_nettype none
module float32_multiplier_tb;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
  } operand_pair_t;

  typedef struct packed {
    logic [31:0] prod;
    logic        uf;
    logic        of;
  } product_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  logic        done;
  logic [31:0] product;
  logic        underflow_flag;
  logic        overflow_flag;

  operand_pair_t pending_pairs[$];
  product_t      expected_products[$];
  int            error_count;
  int            burst_start;
  int            burst_end;
  int            cycle_count;
  bit            stimulus_loaded;

  float32_multiplier dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operand_a(operand_a),
    .operand_b(operand_b),
    .done(done),
    .product(product),
    .underflow_flag(underflow_flag),
    .overflow_flag(overflow_flag)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic fp_is_nan(input logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
  endfunction

  function automatic void split_operand(input logic [31:0] x, output logic [63:0] sig,
                                        output int ex);
    logic [63:0] m;
    int          e;
    m = {41'd0, x[22:0]};
    if (x[30:23] == 8'd0) begin
      e = -126;
      while (m < 64'h80_0000) begin
        m = m << 1;
        e = e - 1;
      end
    end else begin
      m = m | 64'h80_0000;
      e = int'(x[30:23]) - 127;
    end
    sig = m;
    ex = e;
  endfunction

  function automatic logic [63:0] round_shift(input logic [63:0] p, input int s);
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    q = p >> s;
    rem = p & ((64'd1 << s) - 64'd1);
    half = 64'd1 << (s - 1);
    if (rem > half || (rem == half && q[0]))
      q = q + 64'd1;
    return q;
  endfunction

  function automatic logic [31:0] fp_multiply(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] sign;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [63:0] sa;
    logic [63:0] sb;
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] r;
    int          ea;
    int          eb;
    int          be;
    sign = (a ^ b) & fmul_pkg::SignBit;
    ma = a & ~fmul_pkg::SignBit;
    mb = b & ~fmul_pkg::SignBit;
    if (fp_is_nan(a))
      return a | fmul_pkg::QuietBit;
    if (fp_is_nan(b))
      return b | fmul_pkg::QuietBit;
    if (ma == fmul_pkg::ExpMask || mb == fmul_pkg::ExpMask) begin
      if (ma == 32'd0 || mb == 32'd0)
        return fmul_pkg::DefaultNan;
      return sign | fmul_pkg::ExpMask;
    end
    if (ma == 32'd0 || mb == 32'd0)
      return sign;
    split_operand(ma, sa, ea);
    split_operand(mb, sb, eb);
    p = sa * sb;
    be = ea + eb + 127;
    if (p >= (64'd1 << 47))
      be = be + 1;
    else
      p = p << 1;
    if (be >= 1) begin
      if (be >= 255)
        return sign | fmul_pkg::ExpMask;
      q = round_shift(p, 24);
      r = (64'(be - 1) << 23) + q;
      if (r >= 64'(fmul_pkg::ExpMask))
        return sign | fmul_pkg::ExpMask;
      return sign | r[31:0];
    end
    q = round_shift(p, (be < -37) ? 62 : 25 - be);
    return sign | q[31:0];
  endfunction

  function automatic logic [31:0] random_float();
    logic [31:0] x;
    x = $urandom;
    case ($urandom_range(0, 9))
      0: x[30:23] = 8'd0;
      1: x[30:23] = 8'hFF;
      2: x[30:23] = 8'($urandom_range(1, 40));
      3: x[30:23] = 8'($urandom_range(200, 254));
      4: x[30:0] = 31'd0;
      5: x[22:0] = (x[0]) ? 23'd0 : 23'h7F_FFFF;
      default: x[30:23] = 8'($urandom_range(64, 190));
    endcase
    return x;
  endfunction

  task automatic queue_pair(input logic [31:0] a, input logic [31:0] b);
    pending_pairs.push_back('{a: a, b: b});
  endtask

  initial begin
    logic [31:0] corners[12];
    corners = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                32'h7FC0_0001, 32'hFF80_0001, 32'h0000_0001, 32'h007F_FFFF,
                32'h0080_0000, 32'h7F7F_FFFF, 32'h3F80_0000, 32'hFFFF_FFFF};
    stimulus_loaded = 1'b0;
    for (int i = 0; i < 12; i++)
      queue_pair(corners[i], corners[(i * 5 + 3) % 12]);
    queue_pair(32'h7F80_0000, 32'h0000_0000);
    queue_pair(32'h0000_0000, 32'hFF80_0000);
    queue_pair(32'h7F81_0000, 32'h7FC0_0000);
    queue_pair(32'h3F80_0000, 32'hFF80_0001);
    queue_pair(32'h7F00_0000, 32'h4000_0000);
    queue_pair(32'h3F7F_FFFF, 32'h0080_0000);
    queue_pair(32'h3F00_0000, 32'h0000_0001);
    queue_pair(32'h3F40_0000, 32'h0000_0001);
    queue_pair(32'h0000_0001, 32'h0000_0001);
    queue_pair(32'h3FFF_FFFF, 32'h3FFF_FFFF);
    for (int i = 0; i < 1050; i++)
      queue_pair(random_float(), random_float());
    stimulus_loaded = 1'b1;
  end

  initial begin
    rst = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    burst_start = $urandom_range(100, 500);
    burst_end = burst_start + 300;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial cycle_count = 0;

  // driver
  initial begin
    start = 1'b0;
    operand_a = '0;
    operand_b = '0;
  end

  always @(posedge clk) begin
    operand_pair_t next_pair;
    logic [31:0]   expected_word;
    if (!rst && start && !busy) begin
      expected_word = fp_multiply(operand_a, operand_b);
      expected_products.push_back('{prod: expected_word,
                                    uf: (expected_word & fmul_pkg::ExpMask) == 32'd0,
                                    of: (expected_word & ~fmul_pkg::SignBit) ==
                                        fmul_pkg::ExpMask});
    end
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else if (pending_pairs.size() != 0 &&
                 ((cycle_count >= burst_start && cycle_count < burst_end) ||
                  $urandom_range(0, 99) >= 10)) begin
      next_pair = pending_pairs.pop_front();
      start <= 1'b1;
      operand_a <= next_pair.a;
      operand_b <= next_pair.b;
    end else begin
      start <= 1'b0;
      operand_a <= $urandom;
      operand_b <= $urandom;
    end
  end

  // monitor
  initial error_count = 0;

  always @(posedge clk) begin
    product_t oldest;
    if (!rst && done) begin
      if (expected_products.size() == 0) begin
        $error("unexpected transfer: product %h", product);
        error_count = error_count + 1;
      end else begin
        oldest = expected_products.pop_front();
        if (product !== oldest.prod) begin
          $error("product: expected %h, actual %h", oldest.prod, product);
          error_count = error_count + 1;
        end
        if (underflow_flag !== oldest.uf) begin
          $error("underflow_flag: expected %b, actual %b", oldest.uf, underflow_flag);
          error_count = error_count + 1;
        end
        if (overflow_flag !== oldest.of) begin
          $error("overflow_flag: expected %b, actual %b", oldest.of, overflow_flag);
          error_count = error_count + 1;
        end
      end
    end
  end

  initial begin
    wait (stimulus_loaded);
    @(posedge clk);
    while (pending_pairs.size() != 0 || start)
      @(posedge clk);
    while (expected_products.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_products.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  initial begin
    #500000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
+incdir+rtl
rtl/fmul_pkg.sv
rtl/float32_multiplier.sv
rtl/fmul_checker.sv
tb/float32_multiplier_tb.sv
